// ===== src/sws_pkg.sv =====
// package with shared constants and types of the segmenter
`timescale 1ns / 1ps
package sws_pkg;
  localparam int MaxSegment = 256;
  localparam int SampleBits = 24;
  localparam int AddrBits = $clog2(MaxSegment);
  localparam int LenBits = $clog2(MaxSegment + 1);
  localparam int CfgBits = 24;
  localparam int IdxBits = 32;
  // product widths for the deviation test
  localparam int DiffBits = SampleBits + 1;
  localparam int ProdBits = DiffBits + LenBits + 1;
  localparam int NumBits = ProdBits + 1;
  localparam int BoundBits = CfgBits + LenBits;
  localparam logic [CfgBits-1:0] ErrorLimitReset = CfgBits'(2);

  typedef struct packed {
    logic [IdxBits-1:0] break_index;
    logic               forced_break;
    logic               end_of_series;
  } result_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] sample_value;
    logic                         is_final;
  } sample_t;
endpackage

// ===== src/sws_if.sv =====
// valid/ready channel interfaces for samples and breakpoints
`timescale 1ns / 1ps
interface sws_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sws_pkg::SampleBits-1:0] sample_value;
  logic                                 is_final;
  modport source (output valid, sample_value, is_final, input ready);
  modport sink (input valid, sample_value, is_final, output ready);
endinterface

interface sws_result_if;
  logic                          valid;
  logic                          ready;
  logic [sws_pkg::IdxBits-1:0]   break_index;
  logic                          forced_break;
  logic                          end_of_series;
  modport source (output valid, break_index, forced_break, end_of_series, input ready);
  modport sink (input valid, break_index, forced_break, end_of_series, output ready);
endinterface

// ===== src/sws_store.sv =====
// segment sample memory, one write and one registered read port
`timescale 1ns / 1ps
module sws_store (
  input  logic                               clk_i,
  input  logic                               we_i,
  input  logic [sws_pkg::AddrBits-1:0]       waddr_i,
  input  logic signed [sws_pkg::SampleBits-1:0] wdata_i,
  input  logic [sws_pkg::AddrBits-1:0]       raddr_i,
  output logic signed [sws_pkg::SampleBits-1:0] rdata_o
);
  import sws_pkg::*;
  logic signed [SampleBits-1:0] mem_q [MaxSegment];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== src/sws_outq.sv =====
// two-entry result queue between the sequencer and the output channel
`timescale 1ns / 1ps
module sws_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  sws_pkg::result_t    push_data_i,
  output logic                empty_o,
  sws_result_if.source        res
);
  import sws_pkg::*;
  result_t    slot_q [2];
  logic       rd_q, wr_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign pop = res.valid && res.ready;
  assign res.valid = (cnt_q != 2'd0);
  assign res.break_index = slot_q[rd_q].break_index;
  assign res.forced_break = slot_q[rd_q].forced_break;
  assign res.end_of_series = slot_q[rd_q].end_of_series;
  assign empty_o = (cnt_q == 2'd0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0;
      wr_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
    end
  end
endmodule

// ===== src/sws_ctrl.sv =====
// sequencer: scans buffered points against the new line and updates the store
`timescale 1ns / 1ps
module sws_ctrl (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [sws_pkg::CfgBits-1:0]        error_limit_i,
  input  logic                               q_empty_i,
  sws_sample_if.sink                         smp,
  output logic                               push_o,
  output sws_pkg::result_t                   push_data_o,
  output logic                               we_o,
  output logic [sws_pkg::AddrBits-1:0]       waddr_o,
  output logic signed [sws_pkg::SampleBits-1:0] wdata_o,
  output logic [sws_pkg::AddrBits-1:0]       raddr_o,
  input  logic signed [sws_pkg::SampleBits-1:0] rdata_i
);
  import sws_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_ANCHOR, S_SCAN, S_MUL, S_TEST, S_COPY, S_FIN
  } state_e;

  state_e                  state_q;
  logic [LenBits-1:0]      len_q;
  logic [IdxBits-1:0]      pos_q;
  logic signed [SampleBits-1:0] y_q, y0_q;
  logic                    final_q;
  logic [LenBits-1:0]      i_q;
  logic                    ok_q;
  logic signed [ProdBits-1:0] pa_q, pb_q;
  logic [BoundBits-1:0]    bound_q;
  logic [LenBits-1:0]      rd_idx;
  logic signed [NumBits-1:0] num;
  logic [NumBits-1:0]      mag;

  assign smp.ready = (state_q == S_IDLE) && q_empty_i;

  always_comb begin
    rd_idx = i_q;
    raddr_o = rd_idx[AddrBits-1:0];
    num = NumBits'(pa_q) + NumBits'(pb_q);
    mag = num[NumBits-1] ? NumBits'(-num) : NumBits'(num);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q <= '0;
      pos_q <= '0;
      final_q <= 1'b0;
      i_q <= '0;
      ok_q <= 1'b0;
      push_o <= 1'b0;
      push_data_o <= '0;
      we_o <= 1'b0;
      waddr_o <= '0;
      wdata_o <= '0;
      y_q <= '0;
      y0_q <= '0;
      pa_q <= '0;
      pb_q <= '0;
      bound_q <= '0;
    end else begin
      push_o <= 1'b0;
      we_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (smp.valid && smp.ready) begin
            y_q <= smp.sample_value;
            final_q <= smp.is_final;
            bound_q <= BoundBits'(error_limit_i) * BoundBits'(len_q);
            if (len_q == '0) begin
              we_o <= 1'b1;
              waddr_o <= '0;
              wdata_o <= smp.sample_value;
              len_q <= LenBits'(1);
              state_q <= S_FIN;
            end else begin
              i_q <= '0;
              ok_q <= 1'b1;
              state_q <= S_ANCHOR;
            end
          end
        end
        S_ANCHOR: begin
          // read of slot 0 issued this cycle
          i_q <= LenBits'(1);
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (i_q == LenBits'(1)) y0_q <= rdata_i;
          if (i_q >= len_q) begin
            if (ok_q && len_q < LenBits'(MaxSegment)) begin
              we_o <= 1'b1;
              waddr_o <= len_q[AddrBits-1:0];
              wdata_o <= y_q;
              len_q <= len_q + LenBits'(1);
              state_q <= S_FIN;
            end else begin
              push_o <= 1'b1;
              push_data_o <= '{break_index: pos_q - IdxBits'(1),
                               forced_break: ok_q, end_of_series: 1'b0};
              i_q <= len_q - LenBits'(1);
              state_q <= S_COPY;
            end
          end else begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          // rdata holds slot i; y0 valid (slot 0 captured in S_SCAN for i = 1)
          pa_q <= ProdBits'(DiffBits'(y0_q) - DiffBits'(rdata_i))
                  * $signed({1'b0, len_q});
          pb_q <= ProdBits'(DiffBits'(y_q) - DiffBits'(y0_q))
                  * $signed({1'b0, i_q});
          state_q <= S_TEST;
        end
        S_TEST: begin
          if (!(mag < NumBits'(bound_q))) begin
            ok_q <= 1'b0;
            i_q <= len_q;
          end else begin
            i_q <= i_q + LenBits'(1);
          end
          state_q <= S_SCAN;
        end
        S_COPY: begin
          if (i_q != '0) begin
            i_q <= '0;
          end else begin
            // rdata holds slot len-1
            we_o <= 1'b1;
            waddr_o <= '0;
            wdata_o <= rdata_i;
            len_q <= LenBits'(2);
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          // after a re-anchor the new sample goes to slot 1
          if (len_q == LenBits'(2) && waddr_o == '0 && we_o) begin
            we_o <= 1'b1;
            waddr_o <= AddrBits'(1);
            wdata_o <= y_q;
          end
          if (final_q) begin
            push_o <= 1'b1;
            push_data_o <= '{break_index: pos_q, forced_break: 1'b0,
                             end_of_series: 1'b1};
            len_q <= '0;
            pos_q <= '0;
          end else begin
            pos_q <= pos_q + IdxBits'(1);
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== src/sliding_window_segmenter.sv =====
// top level of the sliding-window piecewise-linear segmenter
// channel  | dir | payload
// smp      | in  | sample_value, is_final
// res      | out | break_index, forced_break, end_of_series
// after a sample is taken the block is busy checking the buffered points one
//   at a time and takes no new sample until it is done, limited by the single
//   read port of the segment memory and the three-step test loop
// the first sample of a series skips the test loop; a re-anchor also reads
//   the last buffered point back to become the new anchor
// reset clears the counters and the error limit to 2; memory needs no clearing
// samples are taken only when the result queue is empty; results wait there
`timescale 1ns / 1ps
module sliding_window_segmenter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [sws_pkg::CfgBits-1:0] cfg_wdata_i,
  sws_sample_if.sink                  smp,
  sws_result_if.source                res
);
  import sws_pkg::*;

  logic [CfgBits-1:0] error_limit_q;
  logic                push, q_empty, we;
  result_t             push_data;
  logic [AddrBits-1:0] waddr, raddr;
  logic signed [SampleBits-1:0] wdata, rdata;

  // configuration register; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_limit_q <= ErrorLimitReset;
    end else if (cfg_we_i) begin
      error_limit_q <= cfg_wdata_i;
    end
  end

  sws_ctrl u_ctrl (
    .clk_i, .rst_ni, .error_limit_i(error_limit_q), .q_empty_i(q_empty),
    .smp, .push_o(push), .push_data_o(push_data), .we_o(we),
    .waddr_o(waddr), .wdata_o(wdata), .raddr_o(raddr), .rdata_i(rdata)
  );

  sws_store u_store (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  sws_outq u_outq (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_data),
    .empty_o(q_empty), .res
  );
endmodule

// ===== src/sws_checker.sv =====
// port-level checker for the segmenter, bound to the top level
`timescale 1ns / 1ps
module sws_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_forced_i,
  input logic out_end_i
);
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(out_forced_i && out_end_i)) else $error("forced final");
  a_noacc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i) else $error("accept while result pending");
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i) else $error("back to back accept");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i) else $error("result dropped");
endmodule

bind sliding_window_segmenter sws_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i(smp.valid), .in_ready_i(smp.ready),
  .out_valid_i(res.valid), .out_ready_i(res.ready),
  .out_forced_i(res.forced_break), .out_end_i(res.end_of_series)
);

// ===== verif/sliding_window_segmenter_tb.sv =====
// self-checking testbench of the sliding-window segmenter
`timescale 1ns / 1ps

// keeps the expected breakpoints and matches them against the block's results
class breakpoint_board;
  sws_pkg::result_t pending[$];
  logic signed [sws_pkg::SampleBits-1:0] seg_store[sws_pkg::MaxSegment];
  int unsigned seg_len;
  logic [31:0] next_pos;
  logic [23:0] limit;
  int errors;

  function new();
    seg_len = 0;
    next_pos = 0;
    limit = sws_pkg::ErrorLimitReset;
    errors = 0;
  endfunction

  function void set_limit(logic [23:0] v);
    limit = v;
  endfunction

  // note an accepted sample and predict its breakpoints
  function void note_sample(logic signed [23:0] y, logic fin);
    longint d, y0, bound, num;
    bit ok;
    logic [31:0] n;
    sws_pkg::result_t r;
    n = next_pos;
    if (seg_len == 0) begin
      seg_store[0] = y;
      seg_len = 1;
    end else begin
      d = seg_len;
      y0 = seg_store[0];
      bound = longint'(limit) * d;
      ok = 1;
      for (int i = 1; i < seg_len; i++) begin
        num = (y0 - longint'(seg_store[i])) * d + (longint'(y) - y0) * i;
        if (num < 0) num = -num;
        if (!(num < bound)) begin
          ok = 0;
          break;
        end
      end
      if (ok && seg_len < sws_pkg::MaxSegment) begin
        seg_store[seg_len] = y;
        seg_len++;
      end else begin
        r.break_index = n - 1;
        r.forced_break = ok;
        r.end_of_series = 0;
        pending = {pending, r};
        seg_store[0] = seg_store[seg_len - 1];
        seg_store[1] = y;
        seg_len = 2;
      end
    end
    if (fin) begin
      r.break_index = n;
      r.forced_break = 0;
      r.end_of_series = 1;
      pending = {pending, r};
      seg_len = 0;
      next_pos = 0;
    end else begin
      next_pos = n + 1;
    end
  endfunction

  task report(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  task check_result(sws_pkg::result_t got);
    sws_pkg::result_t exp_r;
    if (pending.size() == 0) begin
      report($sformatf("unexpected breakpoint %0d", got.break_index));
      return;
    end
    exp_r = pending.pop_front();
    if (got.break_index !== exp_r.break_index)
      report($sformatf("break_index %0d, wanted %0d", got.break_index, exp_r.break_index));
    if (got.forced_break !== exp_r.forced_break)
      report($sformatf("forced_break %0b, wanted %0b at %0d", got.forced_break,
                       exp_r.forced_break, exp_r.break_index));
    if (got.end_of_series !== exp_r.end_of_series)
      report($sformatf("end_of_series %0b, wanted %0b at %0d", got.end_of_series,
                       exp_r.end_of_series, exp_r.break_index));
  endtask
endclass

module sliding_window_segmenter_tb;
  import sws_pkg::*;

  localparam int WatchdogLimit = 20000;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [CfgBits-1:0] cfg_wdata_i = '0;

  sws_sample_if smp ();
  sws_result_if res ();

  sliding_window_segmenter i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .smp        (smp.sink),
    .res        (res.source)
  );

  breakpoint_board board = new();

  // 20 ns clock
  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  int idle_cycles = 0;
  bit hold_res = 0;       // long receiver hold-off
  bit res_gaps = 1;       // random receiver stalls on or off
  bit smp_gaps = 1;

  initial begin
    smp.valid = 0;
    smp.sample_value = '0;
    smp.is_final = 0;
    res.ready = 0;
  end

  // watchdog: cycles with no item moving on either channel
  always @(posedge clk_i) begin
    if ((smp.valid && smp.ready) || (res.valid && res.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("sliding_window_segmenter_tb: errors");
      $finish;
    end
  end

  // result checker: sample at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && res.valid && res.ready) begin
      result_t got;
      got.break_index = res.break_index;
      got.forced_break = res.forced_break;
      got.end_of_series = res.end_of_series;
      board.check_result(got);
    end
  end

  // receiver: random stalls drawn per item, changes at the falling edge
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = res_gaps ? $urandom_range(0, 12) : 0;
      repeat (gap) begin
        @(negedge clk_i);
        res.ready <= 0;
      end
      @(negedge clk_i);
      while (hold_res) begin
        res.ready <= 0;
        @(negedge clk_i);
      end
      res.ready <= 1;
      // hold ready until an item moves
      @(posedge clk_i);
      while (!res.valid) @(posedge clk_i);
    end
  end

  // offer one sample and wait for it to be taken
  task send_sample(logic signed [23:0] y, logic fin);
    int gap;
    gap = smp_gaps ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      smp.valid <= 0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    smp.valid <= 1;
    smp.sample_value <= y;
    smp.is_final <= fin;
    @(posedge clk_i);
    while (!smp.ready) @(posedge clk_i);
    board.note_sample(y, fin);
  endtask

  // wait until the block has drained, then some extra cycles
  task drain();
    @(negedge clk_i);
    smp.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (3 * MaxSegment + 20) @(posedge clk_i);
  endtask

  task write_limit(logic [23:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1;
    cfg_wdata_i <= v;
    board.set_limit(v);
    @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  // random sample near a line so segments grow before breaking
  function automatic logic signed [23:0] line_sample(int base, int slope, int k, int noise);
    longint v;
    v = longint'(base) + longint'(slope) * k + $signed($urandom_range(0, 2 * noise)) - noise;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  task random_series(int len, int noise);
    int base, slope;
    base = $signed($urandom_range(0, 2000000)) - 1000000;
    slope = $signed($urandom_range(0, 2000)) - 1000;
    for (int k = 0; k < len; k++)
      send_sample(line_sample(base, slope, k, noise), k == len - 1);
  endtask

  initial begin
    logic [23:0] limits[5];
    limits = '{24'd1, 24'd2, 24'd40, 24'hFFFFFF, 24'd500};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed: reset limit of 2, extremes, first and final sample at once
    send_sample(24'sd0, 1'b1);
    send_sample(24'sh7FFFFF, 1'b0);
    send_sample(24'sh800000, 1'b0);
    send_sample(24'sh7FFFFF, 1'b0);
    send_sample(24'sd0, 1'b0);
    send_sample(24'sd0, 1'b0);
    send_sample(24'sd1, 1'b0);
    send_sample(24'sd5, 1'b1);
    drain();

    // largest limit: a flat series of 300 fills the store and forces a break
    write_limit(24'hFFFFFF);
    smp_gaps = 0;
    res_gaps = 0;
    for (int k = 0; k < 300; k++) send_sample(24'sh7FFFFF, k == 299);
    drain();
    smp_gaps = 1;
    res_gaps = 1;

    // smallest limit: every interior point fails
    write_limit(24'd1);
    for (int k = 0; k < 10; k++)
      send_sample(k[0] ? 24'sh7FFFFF : 24'sh800000, k == 9);
    drain();

    // pressure: receiver holds off while samples keep coming
    write_limit(24'd1);
    hold_res = 1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        hold_res = 0;
      end
      for (int k = 0; k < 20; k++)
        send_sample(24'($urandom()), k == 19);
    join
    drain();

    // random phases through several limits
    for (int p = 0; p < 5; p++) begin
      write_limit(limits[p]);
      for (int s = 0; s < 28; s++) begin
        if (s % 8 == 7) begin
          res_gaps = 0;
          smp_gaps = 0;
        end else begin
          res_gaps = 1;
          smp_gaps = 1;
        end
        case ($urandom_range(0, 5))
          0: for (int k = 0; k < 4; k++)
               send_sample(24'($urandom()), $urandom_range(0, 3) == 0);
          default: random_series($urandom_range(2, 14), $urandom_range(0, 3) * limits[p] / 2);
        endcase
      end
      send_sample(24'($urandom()), 1'b1);
      drain();
    end

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("sliding_window_segmenter_tb: clean");
    end else begin
      $display("sliding_window_segmenter_tb: errors");
    end
    $finish;
  end
endmodule

// ===== files.f =====
src/sws_pkg.sv
src/sws_if.sv
src/sws_store.sv
src/sws_outq.sv
src/sws_ctrl.sv
src/sliding_window_segmenter.sv
src/sws_checker.sv
verif/sliding_window_segmenter_tb.sv
